/* rtl/pearson_correlation_engine_assert.svh */
// Assertion macros shared by the correlation engine RTL.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef PEARSON_CORRELATION_ENGINE_ASSERT_SVH
`define PEARSON_CORRELATION_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/pce_pkg.sv */
// Shared types, widths and operation codes of the correlation engine.
// No dependencies.
package pce_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int MAX_SAMPLES = 4096;
   localparam int FIELD_W     = 16;
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W       = SAMPLE_BITS + CNT_W;
   localparam int SQ_W        = 2 * SAMPLE_BITS - 2 + CNT_W;
   localparam int XY_W        = SQ_W + 1;
   localparam int MAG_W       = CNT_W + SQ_W;
   localparam int HOLD_W      = MAG_W + 2;
   localparam int WIDE_W      = 2 * MAG_W;
   localparam int CHUNK_W     = 14;
   localparam int CHUNKS      = (MAG_W + CHUNK_W - 1) / CHUNK_W;
   localparam int STEP_W      = $clog2(CHUNKS);
   localparam int K_W         = FIELD_W;
   localparam int BIT_CNT_W   = $clog2(K_W);
   localparam int SRCH_W      = WIDE_W + 2 * K_W + 4;

   localparam logic [2:0] OP_N_SXY  = 3'd0;
   localparam logic [2:0] OP_SX_SY  = 3'd1;
   localparam logic [2:0] OP_N_SXX  = 3'd2;
   localparam logic [2:0] OP_SX_SX  = 3'd3;
   localparam logic [2:0] OP_N_SYY  = 3'd4;
   localparam logic [2:0] OP_SY_SY  = 3'd5;
   localparam logic [2:0] OP_DX_DY  = 3'd6;
   localparam logic [2:0] OP_NUM_SQ = 3'd7;

   typedef struct packed {
      logic signed [FIELD_W-1:0] x_sample;
      logic signed [FIELD_W-1:0] y_sample;
      logic                      last;
   } pce_req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] coefficient;
      logic                      degenerate;
      logic                      overflowed;
   } pce_rsp_type;

   typedef struct packed {
      logic       acc_en;
      logic       cos_load;
      logic       mul_start;
      logic [2:0] mul_op;
      logic       srch_init;
      logic       srch_sum;
      logic       srch_cmp;
      logic       out_load;
   } pce_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic degen;
   } pce_sts_type;

   function automatic logic signed [SAMPLE_BITS-1:0] trim_sample(logic [FIELD_W-1:0] v);
      return v[SAMPLE_BITS-1:0];
   endfunction

endpackage

/* rtl/pearson_correlation_engine.sv */
// Streaming Pearson / cosine correlation engine, signed Q1.15 result.
// Pairs are summed at one per cycle while the engine is idle; a last pair then
// runs 8 (Pearson) or 2 (cosine) 56x56 products on the shared multiplier and
// the 16-bit root search. Degenerate series end early.
// Synchronous active-high reset clears sums, drop flag, mode and output valid.
// Depends on pce_pkg, pce_ctrl, pce_datapath and pce_mul.
module pearson_correlation_engine
   import pce_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  pce_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output pce_rsp_type rsp_payload,
   input  logic        csr_write_en,
   input  logic        csr_write_data
);

   // mode register: 0 selects Pearson, 1 selects uncentered cosine
   logic        mode_ff;
   pce_cmd_type cmd;
   pce_sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_write_en) begin
         mode_ff <= csr_write_data;
      end
   end

   // Controller: takes one item per cycle while idle, then on a last item
   // walks the product list, checks for a degenerate series, runs the root
   // search and hands the item to the output register. Items are taken again
   // as soon as the result is loaded, even while it waits on rsp_stall.
   pce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_payload.last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .mode      (mode_ff),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Datapath: running sums, the shared multiplier, numerator and
   // denominators, the square-root-free search for the Q1.15 value and the
   // output register.
   pce_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule

/* rtl/pce_mul.sv */
// Sequential unsigned multiplier, one CHUNK_W-bit digit of b per cycle.
// Depends on pce_pkg.
module pce_mul
   import pce_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [MAG_W-1:0]  a,
   input  logic [MAG_W-1:0]  b,
   output logic              done,
   output logic [WIDE_W-1:0] prod
);

   logic [MAG_W-1:0]          a_ff;
   logic [CHUNKS*CHUNK_W-1:0] b_ff;
   logic [WIDE_W-1:0]         acc_ff;
   logic [STEP_W-1:0]         step_ff;
   logic                      busy_ff;
   logic                      done_ff;
   logic [MAG_W+CHUNK_W-1:0]  part;
   logic [WIDE_W-1:0]         acc_in;

   // most significant digit first: shift the sum up, add the next partial
   assign part   = a_ff * b_ff[CHUNKS*CHUNK_W-1 -: CHUNK_W];
   assign acc_in = (acc_ff << CHUNK_W) + WIDE_W'(part);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(CHUNKS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= (CHUNKS*CHUNK_W)'(b);
         acc_ff <= '0;
      end else if (busy_ff) begin
         b_ff   <= b_ff << CHUNK_W;
         acc_ff <= acc_in;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

/* rtl/pce_datapath.sv */
// Datapath: running sums, correlation terms, root search and result register.
// Depends on pce_pkg and pce_mul.
module pce_datapath
   import pce_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  pce_cmd_type cmd,
   output pce_sts_type sts,
   input  pce_req_type req_payload,
   output pce_rsp_type rsp_payload
);

   // running sums
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [SUM_W-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [SQ_W-1:0]         sxx_ff, sxx_in, syy_ff, syy_in;
   logic signed [XY_W-1:0]  sxy_ff, sxy_in;
   logic                    drop_ff;
   logic                    room;

   logic signed [SAMPLE_BITS-1:0]   x_s, y_s;
   logic signed [2*SAMPLE_BITS-1:0] xx, yy, xy;

   // correlation terms
   logic signed [HOLD_W-1:0] hold_ff, num_ff, prod_lo, prod_s, diff;
   logic [MAG_W-1:0]         dx_ff, dy_ff;
   logic [WIDE_W-1:0]        d_ff, n2_ff;
   logic [2:0]               mop_ff;
   logic                     mneg_ff;

   logic [SUM_W-1:0]  sx_mag, sy_mag;
   logic [XY_W-1:0]   sxy_mag;
   logic [HOLD_W-1:0] num_mag;
   logic [MAG_W-1:0]  mul_a, mul_b;
   logic              mul_neg, mul_done;
   logic [WIDE_W-1:0] mul_prod;

   // root search
   logic signed [SRCH_W-1:0] d_ext, p_ff, qs_ff, ds_ff, r_ff, s_ff;
   logic [K_W-1:0]           k_ff, mask_ff, coef_in;
   logic                     degen;
   pce_rsp_type              rsp_ff;

   assign x_s  = trim_sample(req_payload.x_sample);
   assign y_s  = trim_sample(req_payload.y_sample);
   assign xx   = x_s * x_s;
   assign yy   = y_s * y_s;
   assign xy   = x_s * y_s;
   assign room = cnt_ff < CNT_W'(MAX_SAMPLES);

   assign cnt_in = cnt_ff + CNT_W'(1);
   assign sx_in  = sx_ff + SUM_W'(x_s);
   assign sy_in  = sy_ff + SUM_W'(y_s);
   assign sxx_in = sxx_ff + SQ_W'($unsigned(xx));
   assign syy_in = syy_ff + SQ_W'($unsigned(yy));
   assign sxy_in = sxy_ff + XY_W'(xy);

   always_ff @(posedge clock) begin
      if (reset || cmd.out_load) begin
         cnt_ff  <= '0;
         sx_ff   <= '0;
         sy_ff   <= '0;
         sxx_ff  <= '0;
         syy_ff  <= '0;
         sxy_ff  <= '0;
         drop_ff <= 1'b0;
      end else if (cmd.acc_en) begin
         if (room) begin
            cnt_ff <= cnt_in;
            sx_ff  <= sx_in;
            sy_ff  <= sy_in;
            sxx_ff <= sxx_in;
            syy_ff <= syy_in;
            sxy_ff <= sxy_in;
         end else begin
            drop_ff <= 1'b1;
         end
      end
   end

   assign sx_mag  = sx_ff[SUM_W-1] ? $unsigned(-sx_ff) : $unsigned(sx_ff);
   assign sy_mag  = sy_ff[SUM_W-1] ? $unsigned(-sy_ff) : $unsigned(sy_ff);
   assign sxy_mag = sxy_ff[XY_W-1] ? $unsigned(-sxy_ff) : $unsigned(sxy_ff);
   assign num_mag = num_ff[HOLD_W-1] ? $unsigned(-num_ff) : $unsigned(num_ff);

   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_neg = 1'b0;
      case (cmd.mul_op)
         OP_N_SXY: begin
            mul_a   = MAG_W'(cnt_ff);
            mul_b   = MAG_W'(sxy_mag);
            mul_neg = sxy_ff[XY_W-1];
         end
         OP_SX_SY: begin
            mul_a   = MAG_W'(sx_mag);
            mul_b   = MAG_W'(sy_mag);
            mul_neg = sx_ff[SUM_W-1] ^ sy_ff[SUM_W-1];
         end
         OP_N_SXX: begin
            mul_a = MAG_W'(cnt_ff);
            mul_b = MAG_W'(sxx_ff);
         end
         OP_SX_SX: begin
            mul_a = MAG_W'(sx_mag);
            mul_b = MAG_W'(sx_mag);
         end
         OP_N_SYY: begin
            mul_a = MAG_W'(cnt_ff);
            mul_b = MAG_W'(syy_ff);
         end
         OP_SY_SY: begin
            mul_a = MAG_W'(sy_mag);
            mul_b = MAG_W'(sy_mag);
         end
         OP_DX_DY: begin
            mul_a = dx_ff;
            mul_b = dy_ff;
         end
         OP_NUM_SQ: begin
            mul_a = num_mag[MAG_W-1:0];
            mul_b = num_mag[MAG_W-1:0];
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   pce_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   assign prod_lo = $signed(mul_prod[HOLD_W-1:0]);
   assign prod_s  = mneg_ff ? -prod_lo : prod_lo;
   assign diff    = hold_ff - prod_s;

   always_ff @(posedge clock) begin
      if (cmd.mul_start) begin
         mop_ff  <= cmd.mul_op;
         mneg_ff <= mul_neg;
      end
      if (cmd.cos_load) begin
         num_ff <= HOLD_W'(sxy_ff);
         dx_ff  <= MAG_W'(sxx_ff);
         dy_ff  <= MAG_W'(syy_ff);
      end
      if (mul_done) begin
         case (mop_ff) inside
            OP_N_SXY, OP_N_SXX, OP_N_SYY: hold_ff <= prod_s;
            OP_SX_SY:  num_ff <= diff;
            OP_SX_SX:  dx_ff  <= diff[MAG_W-1:0];
            OP_SY_SY:  dy_ff  <= diff[MAG_W-1:0];
            OP_DX_DY:  d_ff   <= mul_prod;
            OP_NUM_SQ: n2_ff  <= mul_prod;
            default:   hold_ff <= hold_ff;
         endcase
      end
   end

   // greedy search for the largest k with (2k-1)^2 * D <= 2^32 * N, where
   // p = t^2*D, qs = t*D shifted and ds = D shifted track t = 2k-1
   assign d_ext = $signed({{(SRCH_W-WIDE_W){1'b0}}, d_ff});

   always_ff @(posedge clock) begin
      if (cmd.srch_init) begin
         p_ff    <= d_ext;
         qs_ff   <= -(d_ext <<< (K_W + 1));
         ds_ff   <= d_ext <<< (2 * K_W);
         r_ff    <= $signed({{(SRCH_W-WIDE_W-2*K_W){1'b0}}, n2_ff, {(2*K_W){1'b0}}});
         k_ff    <= '0;
         mask_ff <= {1'b1, {(K_W-1){1'b0}}};
      end else if (cmd.srch_sum) begin
         s_ff <= p_ff + qs_ff + ds_ff;
      end else if (cmd.srch_cmp) begin
         if (s_ff <= r_ff) begin
            p_ff  <= s_ff;
            k_ff  <= k_ff | mask_ff;
            qs_ff <= (qs_ff + (ds_ff <<< 1)) >>> 1;
         end else begin
            qs_ff <= qs_ff >>> 1;
         end
         ds_ff   <= ds_ff >>> 2;
         mask_ff <= mask_ff >> 1;
      end
   end

   assign degen = (cnt_ff < CNT_W'(2)) || (dx_ff == '0) || (dy_ff == '0);

   always_comb begin
      if (num_ff[HOLD_W-1]) begin
         coef_in = -k_ff;
      end else if (k_ff[K_W-1]) begin
         coef_in = {1'b0, {(K_W-1){1'b1}}};
      end else begin
         coef_in = k_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.coefficient <= degen ? '0 : $signed(coef_in);
         rsp_ff.degenerate  <= degen;
         rsp_ff.overflowed  <= drop_ff;
      end
   end

   assign sts.mul_done = mul_done;
   assign sts.degen    = degen;
   assign rsp_payload  = rsp_ff;

endmodule

/* rtl/pce_ctrl.sv */
// Controller: sequences accumulation, the product list, root search and output.
// Depends on pce_pkg and pearson_correlation_engine_assert.svh.
`include "pearson_correlation_engine_assert.svh"
module pce_ctrl
   import pce_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_last,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        mode,
   output pce_cmd_type cmd,
   input  pce_sts_type sts
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_LOAD      = 4'd1;
   localparam logic [3:0] ST_MUL_GO    = 4'd2;
   localparam logic [3:0] ST_MUL_WAIT  = 4'd3;
   localparam logic [3:0] ST_CHECK     = 4'd4;
   localparam logic [3:0] ST_SRCH_INIT = 4'd5;
   localparam logic [3:0] ST_SRCH_SUM  = 4'd6;
   localparam logic [3:0] ST_SRCH_CMP  = 4'd7;
   localparam logic [3:0] ST_FINISH    = 4'd8;

   logic [3:0]           state_ff, state_in;
   logic [2:0]           op_ff, op_in, op_next;
   logic [BIT_CNT_W-1:0] bit_ff, bit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 accept;
   logic [6:0]           cmd_pulse;

   assign req_stall = state_ff != ST_IDLE;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      case (op_ff)
         OP_N_SXY: op_next = OP_SX_SY;
         OP_SX_SY: op_next = OP_N_SXX;
         OP_N_SXX: op_next = OP_SX_SX;
         OP_SX_SX: op_next = OP_N_SYY;
         OP_N_SYY: op_next = OP_SY_SY;
         OP_DX_DY: op_next = OP_NUM_SQ;
         default:  op_next = OP_N_SXY;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.mul_op   = op_ff;
      state_in     = state_ff;
      op_in        = op_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.acc_en = 1'b1;
               if (req_last) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            if (mode) begin
               cmd.cos_load = 1'b1;
               state_in     = ST_CHECK;
            end else begin
               op_in    = OP_N_SXY;
               state_in = ST_MUL_GO;
            end
         end
         ST_MUL_GO: begin
            cmd.mul_start = 1'b1;
            state_in      = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (sts.mul_done) begin
               if (op_ff == OP_SY_SY) begin
                  state_in = ST_CHECK;
               end else if (op_ff == OP_NUM_SQ) begin
                  state_in = ST_SRCH_INIT;
               end else begin
                  op_in    = op_next;
                  state_in = ST_MUL_GO;
               end
            end
         end
         ST_CHECK: begin
            if (sts.degen) begin
               state_in = ST_FINISH;
            end else begin
               op_in    = OP_DX_DY;
               state_in = ST_MUL_GO;
            end
         end
         ST_SRCH_INIT: begin
            cmd.srch_init = 1'b1;
            bit_in        = '0;
            state_in      = ST_SRCH_SUM;
         end
         ST_SRCH_SUM: begin
            cmd.srch_sum = 1'b1;
            state_in     = ST_SRCH_CMP;
         end
         ST_SRCH_CMP: begin
            cmd.srch_cmp = 1'b1;
            if (bit_ff == BIT_CNT_W'(K_W - 1)) begin
               state_in = ST_FINISH;
            end else begin
               bit_in   = bit_ff + BIT_CNT_W'(1);
               state_in = ST_SRCH_SUM;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_N_SXY;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   assign cmd_pulse = {cmd.acc_en, cmd.cos_load, cmd.mul_start, cmd.srch_init,
                       cmd.srch_sum, cmd.srch_cmp, cmd.out_load};

   `ASSERT_NEXT(a_last_starts_work, clock, reset, accept && req_last, state_ff == ST_LOAD)
   `ASSERT_IMPLY(a_out_reg_free, clock, reset, cmd.out_load, !rsp_valid_ff || !rsp_stall)
   `ASSERT_IMPLY(a_one_action, clock, reset, 1'b1, $onehot0(cmd_pulse))
   `ASSERT_NEXT(a_load_shows_item, clock, reset, cmd.out_load, rsp_valid_ff)

endmodule
